>>> rtl/core/klvp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// klvp_pkg
// Shared types, codes and widths of the KLV local set parser.
// ----------------------------------------------------------------------------
package klvp_pkg;

  // field widths
  localparam int unsigned SetLenW  = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned KindW    = 2;
  localparam int unsigned IndexW   = 16;
  localparam int unsigned AccW     = 32;
  localparam int unsigned CntW     = 3;
  localparam int unsigned PhaseW   = 3;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 56;

  // default for the declared item length limit
  localparam int unsigned LEN_BITS_DEF = 16;

  // request operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  // result kinds
  localparam logic [KindW-1:0] KIND_VALUE = 2'd0;
  localparam logic [KindW-1:0] KIND_EMPTY = 2'd1;
  localparam logic [KindW-1:0] KIND_NONE  = 2'd2;

  // parser phases
  localparam logic [PhaseW-1:0] PH_IDLE      = 3'd0;
  localparam logic [PhaseW-1:0] PH_TAG       = 3'd1;
  localparam logic [PhaseW-1:0] PH_LEN_FIRST = 3'd2;
  localparam logic [PhaseW-1:0] PH_LEN_MORE  = 3'd3;
  localparam logic [PhaseW-1:0] PH_VALUE     = 3'd4;
  localparam logic [PhaseW-1:0] PH_STOPPED   = 3'd5;

  // ber constants
  localparam logic [ByteW-1:0]   BER_LONG_MASK = 8'h80;
  localparam logic [ByteW-1:0]   BER_CNT_MASK  = 8'h7F;
  localparam logic [ByteW-1:0]   BER_MAX_CNT   = 8'd5;
  localparam logic [SetLenW-1:0] MIN_AT_TAG    = 16'd3;

  // one input request
  typedef struct packed {
    logic               op;
    logic [SetLenW-1:0] set_length;
    logic [ByteW-1:0]   data_byte;
  } in_item_t;

  // one result
  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [ByteW-1:0]   item_tag;
    logic [ByteW-1:0]   value_byte;
    logic [IndexW-1:0]  value_index;
    logic               item_first;
    logic               item_last;
    logic               set_done;
    logic [SetLenW-1:0] leftover_bytes;
  } result_t;

  // step unit to result stage
  typedef struct packed {
    logic    load;
    result_t res;
  } step_out_t;

endpackage

`default_nettype wire

>>> rtl/core/klvp_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// klvp_in_stage
// Input register: holds one accepted request until the step unit takes it.
// ----------------------------------------------------------------------------
module klvp_in_stage (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [klvp_pkg::InDataW-1:0]     in_tdata,  // set_length, data_byte
  input  wire logic                             in_tuser,  // op
  input  wire logic                             take,
  output logic                                  item_valid,
  output klvp_pkg::in_item_t                    item
);

  logic                 valid_r;
  klvp_pkg::in_item_t   item_r;

  // free when empty or when the held request moves on this cycle
  assign in_tready  = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.op         <= in_tuser;
      item_r.set_length <= in_tdata[klvp_pkg::SetLenW-1:0];
      item_r.data_byte  <= in_tdata[klvp_pkg::SetLenW +: klvp_pkg::ByteW];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/klvp_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// klvp_step
// Parser state and the per-byte update: tag, ber length, value bytes, stop.
// ----------------------------------------------------------------------------
module klvp_step #(
  parameter int unsigned LEN_BITS = klvp_pkg::LEN_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  fire,
  input  wire klvp_pkg::in_item_t    item,
  output klvp_pkg::step_out_t        step_out
);

  localparam int unsigned LW = klvp_pkg::SetLenW;
  localparam int unsigned BW = klvp_pkg::ByteW;
  localparam int unsigned AW = klvp_pkg::AccW;
  localparam int unsigned CW = klvp_pkg::CntW;
  localparam int unsigned TotW = AW + 2;

  logic [klvp_pkg::PhaseW-1:0] phase_r, phase_nxt;
  logic [LW-1:0] bytes_rem_r, bytes_rem_nxt;
  logic [LW-1:0] rem_at_tag_r, rem_at_tag_nxt;
  logic [BW-1:0] tag_r, tag_nxt;
  logic [CW-1:0] len_left_r, len_left_nxt;
  logic [CW-1:0] len_cnt_r, len_cnt_nxt;
  logic [AW-1:0] len_acc_r, len_acc_nxt;
  logic [klvp_pkg::IndexW-1:0] val_pos_r, val_pos_nxt;
  logic [LW-1:0] leftover_r, leftover_nxt;

  logic [BW-1:0]   b;
  logic [BW-1:0]   ber_cnt;
  logic            len_done;
  logic            acc_over;
  logic [TotW-1:0] total;
  logic            val_last;
  klvp_pkg::result_t res;
  logic            emit;

  assign b = item.data_byte;

  // per-byte update
  always_comb begin
    phase_nxt      = phase_r;
    bytes_rem_nxt  = bytes_rem_r;
    rem_at_tag_nxt = rem_at_tag_r;
    tag_nxt        = tag_r;
    len_left_nxt   = len_left_r;
    len_cnt_nxt    = len_cnt_r;
    len_acc_nxt    = len_acc_r;
    val_pos_nxt    = val_pos_r;
    leftover_nxt   = leftover_r;
    res            = '0;
    emit           = 1'b0;
    len_done       = 1'b0;
    acc_over       = 1'b0;
    total          = '0;
    ber_cnt        = (b & klvp_pkg::BER_CNT_MASK) + BW'(1);
    val_last       = ({1'b0, {(AW - klvp_pkg::IndexW){1'b0}}, val_pos_r} + (AW + 1)'(1))
                     >= {1'b0, len_acc_r};

    if (fire) begin
      if (item.op == klvp_pkg::OP_START) begin
        // open a new set, dropping any open one
        bytes_rem_nxt  = item.set_length;
        rem_at_tag_nxt = '0;
        tag_nxt        = '0;
        len_left_nxt   = '0;
        len_cnt_nxt    = '0;
        len_acc_nxt    = '0;
        val_pos_nxt    = '0;
        leftover_nxt   = '0;
        if (item.set_length == '0) begin
          emit         = 1'b1;
          res.kind     = klvp_pkg::KIND_NONE;
          res.set_done = 1'b1;
          phase_nxt    = klvp_pkg::PH_IDLE;
        end else begin
          phase_nxt = klvp_pkg::PH_TAG;
        end
      end else if (phase_r != klvp_pkg::PH_IDLE && bytes_rem_r != '0) begin
        case (phase_r)
          klvp_pkg::PH_TAG: begin
            rem_at_tag_nxt = bytes_rem_r;
            if (bytes_rem_r <= klvp_pkg::MIN_AT_TAG) begin
              leftover_nxt = bytes_rem_r;
              phase_nxt    = klvp_pkg::PH_STOPPED;
            end else begin
              tag_nxt   = b;
              phase_nxt = klvp_pkg::PH_LEN_FIRST;
            end
          end
          klvp_pkg::PH_LEN_FIRST: begin
            if ((b & klvp_pkg::BER_LONG_MASK) == '0) begin
              // short form
              len_cnt_nxt = CW'(1);
              len_acc_nxt = AW'(b);
              len_done    = 1'b1;
            end else if (ber_cnt > klvp_pkg::BER_MAX_CNT ||
                         LW'(ber_cnt) > (rem_at_tag_r - LW'(1))) begin
              leftover_nxt = rem_at_tag_r;
              phase_nxt    = klvp_pkg::PH_STOPPED;
            end else begin
              len_cnt_nxt = ber_cnt[CW-1:0];
              len_acc_nxt = '0;
              if (ber_cnt == BW'(1)) begin
                len_done = 1'b1;
              end else begin
                len_left_nxt = ber_cnt[CW-1:0] - CW'(1);
                phase_nxt    = klvp_pkg::PH_LEN_MORE;
              end
            end
          end
          klvp_pkg::PH_LEN_MORE: begin
            // big-endian length bytes
            len_acc_nxt  = {len_acc_r[AW-BW-1:0], b};
            len_left_nxt = len_left_r - CW'(1);
            if (len_left_nxt == '0) begin
              len_done = 1'b1;
            end
          end
          klvp_pkg::PH_VALUE: begin
            emit             = 1'b1;
            res.kind         = klvp_pkg::KIND_VALUE;
            res.item_tag     = tag_r;
            res.value_byte   = b;
            res.value_index  = val_pos_r;
            res.item_first   = (val_pos_r == '0);
            res.item_last    = val_last;
            val_pos_nxt      = val_pos_r + klvp_pkg::IndexW'(1);
            if (val_last) begin
              phase_nxt = klvp_pkg::PH_TAG;
            end
          end
          default: begin
          end
        endcase

        // length complete: the item must fit in the set
        if (len_done) begin
          acc_over = (LEN_BITS < AW) ? ((len_acc_nxt >> LEN_BITS) != '0) : 1'b0;
          total    = TotW'(1) + TotW'(len_cnt_nxt) + TotW'(len_acc_nxt);
          if (acc_over || total > TotW'(rem_at_tag_r)) begin
            leftover_nxt = rem_at_tag_r;
            phase_nxt    = klvp_pkg::PH_STOPPED;
          end else begin
            val_pos_nxt = '0;
            if (len_acc_nxt == '0) begin
              emit           = 1'b1;
              res.kind       = klvp_pkg::KIND_EMPTY;
              res.item_tag   = tag_r;
              res.item_first = 1'b1;
              res.item_last  = 1'b1;
              phase_nxt      = klvp_pkg::PH_TAG;
            end else begin
              phase_nxt = klvp_pkg::PH_VALUE;
            end
          end
        end

        // set end
        bytes_rem_nxt = bytes_rem_r - LW'(1);
        if (bytes_rem_nxt == '0) begin
          if (!emit) begin
            emit     = 1'b1;
            res      = '0;
            res.kind = klvp_pkg::KIND_NONE;
          end
          res.set_done       = 1'b1;
          res.leftover_bytes = (phase_nxt == klvp_pkg::PH_STOPPED) ? leftover_nxt : '0;
          phase_nxt          = klvp_pkg::PH_IDLE;
        end
      end
    end
  end

  assign step_out.load = emit;
  assign step_out.res  = res;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= klvp_pkg::PH_IDLE;
      bytes_rem_r  <= '0;
      rem_at_tag_r <= '0;
      tag_r        <= '0;
      len_left_r   <= '0;
      len_cnt_r    <= '0;
      len_acc_r    <= '0;
      val_pos_r    <= '0;
      leftover_r   <= '0;
    end else begin
      phase_r      <= phase_nxt;
      bytes_rem_r  <= bytes_rem_nxt;
      rem_at_tag_r <= rem_at_tag_nxt;
      tag_r        <= tag_nxt;
      len_left_r   <= len_left_nxt;
      len_cnt_r    <= len_cnt_nxt;
      len_acc_r    <= len_acc_nxt;
      val_pos_r    <= val_pos_nxt;
      leftover_r   <= leftover_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/klvp_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// klvp_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module klvp_out_stage (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire klvp_pkg::step_out_t           step_out,
  output logic                               free,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [klvp_pkg::OutDataW-1:0]      out_tdata,  // item_tag, value_byte,
                                                         // value_index, item_first,
                                                         // item_last, leftover_bytes
  output logic [klvp_pkg::KindW-1:0]         out_tuser,  // kind
  output logic                               out_tlast   // set_done
);

  logic              valid_r;
  klvp_pkg::result_t res_r;

  // room for a new result this cycle
  assign free = !valid_r || out_tready;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= step_out.load;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (free && step_out.load) begin
      res_r <= step_out.res;
    end
  end

  // pack the result
  assign out_tvalid = valid_r;
  assign out_tuser  = res_r.kind;
  assign out_tlast  = res_r.set_done;
  assign out_tdata  = {6'b0, res_r.leftover_bytes, res_r.item_last, res_r.item_first,
                       res_r.value_index, res_r.value_byte, res_r.item_tag};

endmodule

`default_nettype wire

>>> rtl/core/klv_local_set_parser_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// klv_local_set_parser_unit
// KLV local set parser with BER lengths, one byte per request.
//
//   channel  dir  tvalid/tready  tdata (low bit up)                 tuser  tlast
//   in_      in   yes            set_length[15:0], data_byte[23:16]  op     -
//   out_     out  yes            item_tag, value_byte, value_index,  kind   set_done
//                                item_first, item_last, leftover
//
// One request per cycle sustained while the output is not stalled; a result
// becomes valid after its request is accepted: the input register takes the
// request, then the step logic loads the result register. The parser state
// updates in the same cycle the request leaves the input register. rst_n
// synchronously clears the parser state and both stage valid flags. A stalled
// output holds the result and the input register, and in_tready falls once
// both are full.
// ----------------------------------------------------------------------------
module klv_local_set_parser_unit #(
  parameter int unsigned LEN_BITS = klvp_pkg::LEN_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [klvp_pkg::InDataW-1:0]  in_tdata,   // set_length, data_byte
  input  wire logic                          in_tuser,   // op
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [klvp_pkg::OutDataW-1:0]      out_tdata,  // item_tag, value_byte,
                                                         // value_index, item_first,
                                                         // item_last, leftover_bytes
  output logic [klvp_pkg::KindW-1:0]         out_tuser,  // kind
  output logic                               out_tlast   // set_done
);

  logic                item_valid;
  klvp_pkg::in_item_t  item;
  logic                out_free;
  logic                fire;
  klvp_pkg::step_out_t step_out;

  // a held request moves when the result register has room
  assign fire = item_valid && out_free;

  // input register
  klvp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  // parser state and byte step
  klvp_step #(
    .LEN_BITS (LEN_BITS)
  ) u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .item     (item),
    .step_out (step_out)
  );

  // result register
  klvp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_out   (step_out),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
